FILE: rtl/core/allgs_pkg.sv
`default_nettype none

package allgs_pkg;

    localparam int RANK_W  = 6;
    localparam int SIZE_W  = 7;
    localparam int CNT_W   = 24;
    localparam int EBYTE_W = 9;
    localparam int XFER_W  = 30;
    localparam int THR_W   = 40;
    localparam int PROD_W  = CNT_W + EBYTE_W;
    localparam int STEP_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    localparam logic [THR_W-1:0] LONG_THR_RST  = 40'd524288;
    localparam logic [THR_W-1:0] SHORT_THR_RST = 40'd81920;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE    = 4'd0;
    localparam step_t S_DIV     = 4'd1;
    localparam step_t S_TOTAL   = 4'd2;
    localparam step_t S_SEL     = 4'd3;
    localparam step_t S_RD      = 4'd4;
    localparam step_t S_BR      = 4'd5;
    localparam step_t S_BR_MUL  = 4'd6;
    localparam step_t S_BR_REM  = 4'd7;
    localparam step_t S_RING    = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_THR  = 2'd0,
        REG_SHORT_THR = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ALG_RD    = 2'd0,
        ALG_BRUCK = 2'd1,
        ALG_RING  = 2'd2
    } alg_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_START,
        J_DIV,
        J_DISPATCH,
        J_EMIT,
        J_EMIT_BR,
        J_EMIT_ONE
    } jump_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_RD,
        EM_BR,
        EM_BR_REM,
        EM_RING
    } emit_t;

    typedef struct packed {
        logic  in_rdy;
        logic  div_en;
        logic  total_en;
        logic  sel_en;
        logic  rem_en;
        emit_t emit;
        jump_t jump;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic start;
        logic div_done;
        logic fire;
        logic last;
        logic br_done;
        logic rem_pend;
        logic single;
        alg_t alg;
    } stat_t;

    function automatic ctl_t ctl_rom(input step_t step);
        ctl_t c;
        c = '{in_rdy: 1'b0, div_en: 1'b0, total_en: 1'b0, sel_en: 1'b0, rem_en: 1'b0,
              emit: EM_NONE, jump: J_NEXT, target: S_IDLE};
        unique case (step)
            S_IDLE:
            begin
                c.in_rdy = 1'b1;
                c.jump   = J_START;
            end
            S_DIV:
            begin
                c.div_en = 1'b1;
                c.jump   = J_DIV;
            end
            S_TOTAL:
            begin
                c.total_en = 1'b1;
            end
            S_SEL:
            begin
                c.sel_en = 1'b1;
                c.jump   = J_DISPATCH;
            end
            S_RD:
            begin
                c.emit = EM_RD;
                c.jump = J_EMIT;
            end
            S_BR:
            begin
                c.emit = EM_BR;
                c.jump = J_EMIT_BR;
            end
            S_BR_MUL:
            begin
                c.rem_en = 1'b1;
            end
            S_BR_REM:
            begin
                c.emit = EM_BR_REM;
                c.jump = J_EMIT_ONE;
            end
            S_RING:
            begin
                c.emit = EM_RING;
                c.jump = J_EMIT;
            end
            default:
            begin
                c.jump = J_EMIT_ONE;
                c.emit = EM_NONE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/allgs_sequencer.sv
`default_nettype none

module allgs_sequencer
    import allgs_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    step_t step_reg;
    step_t step_next;
    step_t step_inc;

    assign ctl      = ctl_rom(step_reg);
    assign step_inc = step_reg + step_t'(1);

    always_comb
    begin
        step_next = step_reg;
        unique case (ctl.jump)
            J_NEXT:
            begin
                step_next = step_inc;
            end
            J_START:
            begin
                if (stat.start)
                    step_next = step_inc;
            end
            J_DIV:
            begin
                if (stat.div_done)
                    step_next = step_inc;
            end
            J_DISPATCH:
            begin
                if (stat.single)
                    step_next = S_IDLE;
                else
                begin
                    case (stat.alg)
                        ALG_RD:    step_next = S_RD;
                        ALG_BRUCK: step_next = S_BR;
                        default:   step_next = S_RING;
                    endcase
                end
            end
            J_EMIT:
            begin
                if (stat.fire && stat.last)
                    step_next = ctl.target;
            end
            J_EMIT_BR:
            begin
                if (stat.fire && stat.br_done)
                    step_next = stat.rem_pend ? step_inc : ctl.target;
            end
            J_EMIT_ONE:
            begin
                if (stat.fire || ctl.emit == EM_NONE)
                    step_next = ctl.target;
            end
            default:
            begin
                step_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/allgs_datapath.sv
`default_nettype none

module allgs_datapath
    import allgs_pkg::*;
#(
    parameter int MAX_RANKS = 64
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  ctl_t                   ctl,
    output stat_t                  stat,
    input  wire                    in_fire,
    input  wire [IN_DATA_W-1:0]    in_data,
    input  wire [THR_W-1:0]        long_thr,
    input  wire [THR_W-1:0]        short_thr,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [RANK_W-1:0]      out_dest,
    output logic [RANK_W-1:0]      out_source,
    output logic [XFER_W-1:0]      out_xfer,
    output alg_t                   out_alg,
    output logic                   out_last
);

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_RANKS);
    localparam int DIV_CNT_W = $clog2(RANK_W);

    logic [RANK_W-1:0]    in_rank;
    logic [SIZE_W-1:0]    in_size;
    logic [CNT_W-1:0]     in_cnt;
    logic [EBYTE_W-1:0]   in_ebytes;
    logic [CNT_W-1:0]     in_scnt;
    logic [SIZE_W-1:0]    size_sat;

    logic [SIZE_W-1:0]    size_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [EBYTE_W-1:0]   ebytes_reg;
    logic [RANK_W-1:0]    rank_sh_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [THR_W-1:0]     total_reg;
    alg_t                 alg_reg;
    logic [SIZE_W-1:0]    p_reg;
    logic [XFER_W-1:0]    cur_reg;

    logic [SIZE_W-1:0]    rem_sh;
    logic [SIZE_W-1:0]    rem_next;
    logic [RANK_W-1:0]    rank;
    logic                 pow2;
    alg_t                 alg_sel;
    logic [SIZE_W-1:0]    p2;
    logic [SIZE_W-1:0]    br_src_sum;
    logic [RANK_W-1:0]    br_src;
    logic [RANK_W-1:0]    br_dst;
    logic [RANK_W-1:0]    ring_left;
    logic [RANK_W-1:0]    ring_right;
    logic [SIZE_W+CNT_W-1:0] rem_prod;
    logic                 out_free;
    logic                 fire;
    logic [RANK_W-1:0]    em_dest;
    logic [RANK_W-1:0]    em_source;
    logic [XFER_W-1:0]    em_xfer;
    logic                 em_last;

    logic                 out_valid_reg;
    logic [RANK_W-1:0]    out_dest_reg;
    logic [RANK_W-1:0]    out_source_reg;
    logic [XFER_W-1:0]    out_xfer_reg;
    alg_t                 out_alg_reg;
    logic                 out_last_reg;

    assign in_rank   = in_data[5:0];
    assign in_size   = in_data[12:6];
    assign in_cnt    = in_data[36:13];
    assign in_ebytes = in_data[45:37];
    assign in_scnt   = in_data[69:46];

    always_comb
    begin
        if (in_size == '0)
            size_sat = SIZE_W'(1);
        else if (in_size > SIZE_MAX)
            size_sat = SIZE_MAX;
        else
            size_sat = in_size;
    end

    // rank modulo size, one rank bit per cycle
    assign rem_sh   = {rem_reg[SIZE_W-2:0], rank_sh_reg[RANK_W-1]};
    assign rem_next = (rem_sh >= size_reg) ? rem_sh - size_reg : rem_sh;
    assign rank     = rem_reg[RANK_W-1:0];

    assign pow2 = ((size_reg & (size_reg - SIZE_W'(1))) == '0);

    always_comb
    begin
        if (total_reg < long_thr && pow2)
            alg_sel = ALG_RD;
        else if (total_reg < short_thr)
            alg_sel = ALG_BRUCK;
        else
            alg_sel = ALG_RING;
    end

    assign p2 = {p_reg[SIZE_W-2:0], 1'b0};

    assign br_src_sum = {1'b0, rank} + p_reg;
    assign br_src = (br_src_sum >= size_reg) ? RANK_W'(br_src_sum - size_reg)
                                             : br_src_sum[RANK_W-1:0];
    assign br_dst = ({1'b0, rank} >= p_reg) ? RANK_W'({1'b0, rank} - p_reg)
                                            : RANK_W'({1'b0, rank} + size_reg - p_reg);

    assign ring_right = ({1'b0, rank} + SIZE_W'(1) == size_reg) ? '0 : rank + RANK_W'(1);
    assign ring_left  = (rank == '0) ? RANK_W'(size_reg - SIZE_W'(1)) : rank - RANK_W'(1);

    assign rem_prod = (SIZE_W+CNT_W)'(size_reg - p_reg) * (SIZE_W+CNT_W)'(cnt_reg);

    always_comb
    begin
        em_dest   = rank;
        em_source = rank;
        em_xfer   = cur_reg;
        em_last   = 1'b0;
        case (ctl.emit)
            EM_RD:
            begin
                em_dest   = rank ^ p_reg[RANK_W-1:0];
                em_source = rank ^ p_reg[RANK_W-1:0];
                em_last   = (p2 >= size_reg);
            end
            EM_BR:
            begin
                em_dest   = br_dst;
                em_source = br_src;
                em_last   = stat.br_done && !stat.rem_pend;
            end
            EM_BR_REM:
            begin
                em_dest   = br_dst;
                em_source = br_src;
                em_last   = 1'b1;
            end
            EM_RING:
            begin
                em_dest   = ring_right;
                em_source = ring_left;
                em_xfer   = XFER_W'(cnt_reg);
                em_last   = (p_reg == size_reg - SIZE_W'(1));
            end
            default:
            begin
                em_last = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = (ctl.emit != EM_NONE) && out_free;

    assign stat.start    = in_fire && (in_scnt != '0);
    assign stat.div_done = ctl.div_en && (div_cnt_reg == DIV_CNT_W'(RANK_W - 1));
    assign stat.fire     = fire;
    assign stat.last     = em_last;
    assign stat.br_done  = (p2 > (size_reg >> 1));
    assign stat.rem_pend = (size_reg > p2);
    assign stat.single   = (size_reg == SIZE_W'(1));
    assign stat.alg      = alg_sel;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            size_reg    <= size_sat;
            cnt_reg     <= in_cnt;
            ebytes_reg  <= in_ebytes;
            rank_sh_reg <= in_rank;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (ctl.div_en)
        begin
            rank_sh_reg <= {rank_sh_reg[RANK_W-2:0], 1'b0};
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            prod_reg    <= PROD_W'(cnt_reg) * PROD_W'(ebytes_reg);
        end
        if (ctl.total_en)
            total_reg <= THR_W'(prod_reg) * THR_W'(size_reg);
        if (ctl.sel_en)
        begin
            alg_reg <= alg_sel;
            p_reg   <= SIZE_W'(1);
            cur_reg <= XFER_W'(cnt_reg);
        end
        if (ctl.rem_en)
            cur_reg <= rem_prod[XFER_W-1:0];
        if (fire)
        begin
            if (ctl.emit == EM_RING)
                p_reg <= p_reg + SIZE_W'(1);
            else
            begin
                p_reg   <= p2;
                cur_reg <= {cur_reg[XFER_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_dest_reg   <= em_dest;
            out_source_reg <= em_source;
            out_xfer_reg   <= em_xfer;
            out_alg_reg    <= alg_reg;
            out_last_reg   <= em_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_dest   = out_dest_reg;
    assign out_source = out_source_reg;
    assign out_xfer   = out_xfer_reg;
    assign out_alg    = out_alg_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/allgather_schedule_generator_top.sv
`default_nettype none

// Allgather schedule generator. Each word on the s_ side describes one
// allgather call; the block answers with its schedule of send/receive
// exchanges on the m_ side, tlast marking the final exchange of a call (a
// zero send count or a group of one gives no exchanges). Control runs from a
// small microcode table. After a word is taken the rank is reduced modulo the
// group size one rank bit at a time, then the byte total is formed in a total
// step and the algorithm is chosen in a select step; exchanges then leave one
// per cycle while m_tready stays high, with a multiply step before a Bruck
// remainder step, and the block returns to take the next word in the cycle
// after the final exchange. Thresholds are written over the cfg port; the
// user must write them only while the block is idle, which the block itself
// leaves unchecked: index 0 is the recursive doubling limit, index 1 the
// Bruck limit.

module allgather_schedule_generator_top
    import allgs_pkg::*;
#(
    parameter int MAX_RANKS = 64
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    // my_rank[5:0], group_size[12:6], elem_count[36:13], elem_bytes[45:37],
    // send_count[69:46]
    input  wire [IN_DATA_W-1:0]      s_tdata,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    // dest_rank[5:0], source_rank[11:6], xfer_count[41:12]
    output logic [OUT_DATA_W-1:0]    m_tdata,
    // algorithm[1:0]
    output logic [1:0]               m_tuser,
    output logic                     m_tlast,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire [CFG_IDX_W-1:0]      cfg_index,
    input  wire [THR_W-1:0]          cfg_data
);

    ctl_t               ctl;
    stat_t              stat;
    logic               in_fire;
    logic [THR_W-1:0]   long_thr_reg;
    logic [THR_W-1:0]   short_thr_reg;
    logic [RANK_W-1:0]  out_dest;
    logic [RANK_W-1:0]  out_source;
    logic [XFER_W-1:0]  out_xfer;
    alg_t               out_alg;

    assign cfg_ready = 1'b1;
    assign s_tready  = ctl.in_rdy;
    assign in_fire   = s_tvalid && ctl.in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_thr_reg  <= LONG_THR_RST;
            short_thr_reg <= SHORT_THR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_THR:  long_thr_reg  <= cfg_data;
                REG_SHORT_THR: short_thr_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    allgs_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    allgs_datapath #(
        .MAX_RANKS (MAX_RANKS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .in_fire    (in_fire),
        .in_data    (s_tdata),
        .long_thr   (long_thr_reg),
        .short_thr  (short_thr_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_dest   (out_dest),
        .out_source (out_source),
        .out_xfer   (out_xfer),
        .out_alg    (out_alg),
        .out_last   (m_tlast)
    );

    assign m_tdata = {(OUT_DATA_W - 2*RANK_W - XFER_W)'(0), out_xfer, out_source, out_dest};
    assign m_tuser = out_alg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_allgather_schedule_generator_top.sv
`default_nettype none

module tb_allgather_schedule_generator_top;
    import allgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RANKS = 64;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 16;
    localparam int TAIL      = 80;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 50;
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    typedef struct packed {
        logic [RANK_W-1:0] dest;
        logic [RANK_W-1:0] src;
        logic [XFER_W-1:0] count;
        alg_t              alg;
        logic              last;
    } exchange_t;

    class exchange_ledger;
        logic [THR_W-1:0] long_thr;
        logic [THR_W-1:0] short_thr;
        exchange_t        pending_q[$];
        int               mismatches;

        function new();
            long_thr   = LONG_THR_RST;
            short_thr  = SHORT_THR_RST;
            mismatches = 0;
        endfunction

        function void set_threshold(reg_idx_t idx, logic [THR_W-1:0] v);
            if (idx == REG_LONG_THR)
                long_thr = v;
            else if (idx == REG_SHORT_THR)
                short_thr = v;
        endfunction

        function void push_exchange(int unsigned dst, int unsigned src, logic [63:0] cnt,
                                    alg_t alg);
            exchange_t e;
            e.dest  = RANK_W'(dst);
            e.src   = RANK_W'(src);
            e.count = XFER_W'(cnt);
            e.alg   = alg;
            e.last  = 1'b0;
            pending_q.push_back(e);
        endfunction

        function void note_call(logic [IN_DATA_W-1:0] w);
            logic [RANK_W-1:0]  rank;
            logic [SIZE_W-1:0]  size_f;
            logic [CNT_W-1:0]   cnt;
            logic [CNT_W-1:0]   scnt;
            logic [EBYTE_W-1:0] eb;
            logic [63:0]        total;
            logic [63:0]        cur;
            int unsigned        size;
            int unsigned        r;
            int unsigned        p;
            int                 first;
            first  = pending_q.size();
            rank   = w[5:0];
            size_f = w[12:6];
            cnt    = w[36:13];
            eb     = w[45:37];
            scnt   = w[69:46];
            if (scnt == 0)
                return;
            if (size_f == 0)
                size = 1;
            else if (size_f > MAX_RANKS)
                size = MAX_RANKS;
            else
                size = size_f;
            r     = rank % size;
            total = 64'(cnt) * 64'(size) * 64'(eb);
            cur   = 64'(cnt);
            if (total < 64'(long_thr) && (size & (size - 1)) == 0) begin
                for (p = 1; p < size; p = p << 1)
                begin
                    push_exchange(r ^ p, r ^ p, cur, ALG_RD);
                    cur = cur << 1;
                end
            end
            else if (total < 64'(short_thr)) begin
                p = 1;
                while (p <= size / 2)
                begin
                    push_exchange((r + size - p) % size, (r + p) % size, cur, ALG_BRUCK);
                    cur = cur << 1;
                    p   = p << 1;
                end
                if (size > p)
                    push_exchange((r + size - p) % size, (r + p) % size,
                                  64'(size - p) * 64'(cnt), ALG_BRUCK);
            end
            else begin
                for (p = 1; p < size; p++)
                    push_exchange((r + 1) % size, (r + size - 1) % size, 64'(cnt), ALG_RING);
            end
            if (pending_q.size() > first)
                pending_q[pending_q.size() - 1].last = 1'b1;
        endfunction

        function void check_exchange(exchange_t got);
            exchange_t want;
            if (pending_q.size() == 0) begin
                $display("%0t ns: unexpected exchange: dest %0d src %0d count %0d alg %0d last %0b",
                         $time, got.dest, got.src, got.count, got.alg, got.last);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                $display("%0t ns: exchange mismatch: expected dest %0d src %0d count %0d alg %0d last %0b",
                         $time, want.dest, want.src, want.count, want.alg, want.last);
                $display("%0t ns:                      actual dest %0d src %0d count %0d alg %0d last %0b",
                         $time, got.dest, got.src, got.count, got.alg, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [THR_W-1:0]      cfg_data = '0;

    int             idle_pct = 0;
    int             stall_pct = 0;
    int             cycles = 0;
    exchange_ledger ledger;

    allgather_schedule_generator_top #(
        .MAX_RANKS(MAX_RANKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        exchange_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.dest  = m_tdata[5:0];
            got.src   = m_tdata[11:6];
            got.count = m_tdata[41:12];
            got.alg   = alg_t'(m_tuser);
            got.last  = m_tlast;
            ledger.check_exchange(got);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_call(int unsigned rank, int unsigned size,
                                                       int unsigned cnt, int unsigned eb,
                                                       int unsigned scnt);
        return {2'b00, CNT_W'(scnt), EBYTE_W'(eb), CNT_W'(cnt), SIZE_W'(size), RANK_W'(rank)};
    endfunction

    function automatic logic [IN_DATA_W-1:0] make_call();
        int unsigned size;
        int unsigned rank;
        int unsigned cnt;
        int unsigned eb;
        int unsigned scnt;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            size = 1 << $urandom_range(6);
        else if (pick < 85)
            size = $urandom_range(64, 1);
        else if (pick < 92)
            size = $urandom_range(127, 65);
        else if (pick < 95)
            size = 0;
        else
            size = $urandom_range(64, 2);
        if ($urandom_range(99) < 85 && size > 0 && size <= MAX_RANKS)
            rank = $urandom_range(size - 1);
        else
            rank = $urandom_range(63);
        pick = $urandom_range(99);
        if (pick < 50)
            cnt = $urandom_range(255);
        else if (pick < 80)
            cnt = $urandom_range(65535);
        else if (pick < 90)
            cnt = $urandom() & 32'hFF_FFFF;
        else
            cnt = $urandom_range(1) ? 32'hFF_FFFF : 0;
        pick = $urandom_range(99);
        if (pick < 80)
            eb = $urandom_range(256, 1);
        else if (pick < 90)
            eb = $urandom_range(511, 257);
        else if (pick < 95)
            eb = 0;
        else
            eb = $urandom_range(1) ? 511 : 256;
        pick = $urandom_range(99);
        if (pick < 8)
            scnt = 0;
        else if (pick < 15)
            scnt = 32'hFF_FFFF;
        else
            scnt = $urandom_range(32'hFF_FFFF, 1);
        return pack_call(rank, size, cnt, eb, scnt);
    endfunction

    function automatic logic [THR_W-1:0] rand_threshold();
        logic [THR_W-1:0] v;
        v = {8'($urandom()), 32'($urandom())};
        return v >> $urandom_range(39, 14);
    endfunction

    task automatic send_call(logic [IN_DATA_W-1:0] w);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        ledger.note_call(w);
    endtask

    task automatic drain(int settle);
        s_tvalid <= 1'b0;
        while (ledger.pending_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_thresholds(logic [THR_W-1:0] long_v, logic [THR_W-1:0] short_v);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LONG_THR;
        cfg_data  <= long_v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.set_threshold(REG_LONG_THR, long_v);
        cfg_index <= REG_SHORT_THR;
        cfg_data  <= short_v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.set_threshold(REG_SHORT_THR, short_v);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        ledger = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default thresholds
        send_call(pack_call(3, 8, 10, 4, 0));
        send_call(pack_call(0, 1, 100, 4, 7));
        send_call(pack_call(5, 0, 100, 4, 7));
        send_call(pack_call(63, 64, 1, 1, 1));
        send_call(pack_call(0, 64, 24'hFF_FFFF, 256, 24'hFF_FFFF));
        send_call(pack_call(3, 7, 5, 4, 9));
        send_call(pack_call(36, 127, 3, 2, 1));
        send_call(pack_call(63, 65, 2, 8, 1));
        send_call(pack_call(50, 6, 9, 3, 1));
        send_call(pack_call(4, 5, 24'hFF_FFFF, 0, 1));
        send_call(pack_call(2, 3, 100, 511, 1));
        send_call(pack_call(9, 16, 0, 256, 1));
        send_call(pack_call(1, 2, 77, 1, 24'hFF_FFFF));
        send_call(pack_call(2, 4, 512, 256, 1));
        send_call(pack_call(2, 4, 511, 256, 1));
        send_call(pack_call(1, 5, 64, 256, 1));
        send_call(pack_call(1, 5, 63, 256, 1));
        send_call(pack_call(17, 64, 24'hFF_FFFF, 511, 3));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain(SETTLE);
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 66;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 66;
                end
                default:
                begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            case (ph)
                0: write_thresholds(LONG_THR_RST, SHORT_THR_RST);
                1: write_thresholds('0, '0);
                2: write_thresholds(THR_MAX, THR_MAX);
                3: write_thresholds('0, THR_MAX);
                4: write_thresholds(THR_MAX, '0);
                default: write_thresholds(rand_threshold(), rand_threshold());
            endcase
            if (ph == 3) begin
                // power-of-two groups through Bruck: no remainder step
                send_call(pack_call(5, 8, 3, 1, 1));
                send_call(pack_call(63, 64, 24'hFF_FFFF, 511, 1));
                send_call(pack_call(0, 2, 1, 1, 1));
            end
            repeat (PER_PHASE) send_call(make_call());
        end

        drain(TAIL);
        if (ledger.mismatches == 0 && ledger.pending_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
